// ===== design/websocket_frame_deframer_defines.svh =====
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// condition must hold at every clock edge
`define WFD_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define WFD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/wfd_pkg.sv =====
`default_nettype none

package wfd_pkg;

	// parser phases
	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXTLEN,
		PH_DATA,
		PH_CLOSE,
		PH_STOP
	} phase_t;

	// opcodes
	localparam logic [3:0] OP_CONT  = 4'd0;
	localparam logic [3:0] OP_TEXT  = 4'd1;
	localparam logic [3:0] OP_CLOSE = 4'd8;

	// 7-bit length markers for extended lengths
	localparam logic [6:0] LEN16_MARK = 7'd126;
	localparam logic [6:0] LEN64_MARK = 7'd127;
	localparam logic [3:0] LEN16_BYTES = 4'd2;
	localparam logic [3:0] LEN64_BYTES = 4'd8;

	localparam int REM_W = 63;

	// result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_CLOSE = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	// error codes
	localparam logic [1:0] ERR_MASKED  = 2'd0;
	localparam logic [1:0] ERR_LEN_MSB = 2'd1;
	localparam logic [1:0] ERR_TYPE    = 2'd2;

	localparam logic [15:0] ABSENT_CLOSE_RESET = 16'd1005;

	// one result item plus its presence flag
	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic [7:0]  data;
		logic        last;
		logic [15:0] status;
		logic [1:0]  err;
	} result_t;

endpackage

`default_nettype wire

// ===== design/websocket_frame_deframer.sv =====
// path: a byte accepted into the input register is parsed from there, and its
//   result, if any, is captured in the output register
// throughput: one byte per cycle while the output is not stalled; the parser state updates once per byte
// reset: arst_n clears the valid flags of both stages, returns the parser state to the first
//   header byte and reloads the default close status (1005)
`default_nettype none
`include "websocket_frame_deframer_defines.svh"

module websocket_frame_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [7:0]       data_byte,
	output logic             message_last,
	output logic [15:0]      close_status,
	output logic [1:0]       error_code
);

	logic [15:0]      absent_close_status_q;
	logic             valid_s1;
	logic [7:0]       rx_byte_s1;
	logic             out_valid_q;
	logic [1:0]       kind_q;
	logic [7:0]       data_byte_q;
	logic             message_last_q;
	logic [15:0]      close_status_q;
	logic [1:0]       error_code_q;
	logic             stall;
	logic             step;
	wfd_pkg::result_t res;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			absent_close_status_q <= wfd_pkg::ABSENT_CLOSE_RESET;
		end else if (cfg_wr_en) begin
			absent_close_status_q <= cfg_wr_data;
		end
	end

	// flow control
	assign stall    = out_valid_q && !out_ready;
	assign step     = valid_s1 && !stall;
	assign in_ready = !valid_s1 || !stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	wfd_parse u_parse (
		.clk                 (clk),
		.arst_n              (arst_n),
		.step                (step),
		.rx_byte             (rx_byte_s1),
		.absent_close_status (absent_close_status_q),
		.res                 (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!stall) begin
			out_valid_q <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			kind_q         <= res.kind;
			data_byte_q    <= res.data;
			message_last_q <= res.last;
			close_status_q <= res.status;
			error_code_q   <= res.err;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign data_byte    = data_byte_q;
	assign message_last = message_last_q;
	assign close_status = close_status_q;
	assign error_code   = error_code_q;

	// checks
	`WFD_ASSERT_SAME(a_err_code_range, out_valid && (kind == wfd_pkg::KIND_ERROR),
		error_code != 2'd3, "error item with undefined code")
	`WFD_ASSERT_SAME(a_non_data_clean, out_valid && (kind != wfd_pkg::KIND_DATA),
		(data_byte == 8'd0) && !message_last, "non-data item carries data")
	`WFD_ASSERT_NEXT(a_silent_after_stop, out_valid && out_ready
		&& ((kind == wfd_pkg::KIND_CLOSE) || (kind == wfd_pkg::KIND_ERROR)),
		!out_valid, "item produced after close or error")
	`WFD_ASSERT_ALWAYS(a_ready_when_empty, valid_s1 || in_ready,
		"input stalled with empty input register")

endmodule

`default_nettype wire

// ===== design/wfd_parse.sv =====
`default_nettype none

module wfd_parse (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [7:0]       rx_byte,
	input  wire logic [15:0]      absent_close_status,
	output wfd_pkg::result_t      res
);

	wfd_pkg::phase_t                phase_q, phase_d;
	logic [3:0]                     len_left_q, len_left_d;
	logic [wfd_pkg::REM_W-1:0]      rem_q, rem_d;
	logic                           final_q, final_d;
	logic [3:0]                     ftype_q, ftype_d;
	logic [3:0]                     mtype_q, mtype_d;
	logic [15:0]                    shift_q, shift_d;
	logic [1:0]                     seen_q, seen_d;

	// shared decode
	logic [6:0]                     len7;
	logic                           mask_err;
	logic                           len_ext;
	logic                           msb_err;
	logic [3:0]                     len_left_dec;
	logic [wfd_pkg::REM_W-1:0]      ext_rem;
	logic [wfd_pkg::REM_W-1:0]      rem_dec;
	logic                           rem_dec_zero;
	logic [1:0]                     seen_inc;
	logic [15:0]                    shift_new;
	logic                           start_go;
	logic [wfd_pkg::REM_W-1:0]      start_rem;
	logic                           start_zero;
	logic                           start_close;
	logic                           msg_text;
	wfd_pkg::phase_t                start_phase;

	always_comb begin
		len7         = rx_byte[6:0];
		mask_err     = rx_byte[7];
		len_ext      = len7 inside {wfd_pkg::LEN16_MARK, wfd_pkg::LEN64_MARK};
		msb_err      = (len_left_q == wfd_pkg::LEN64_BYTES) && rx_byte[7];
		len_left_dec = (len_left_q != 4'd0) ? len_left_q - 4'd1 : 4'd0;
		ext_rem      = {rem_q[wfd_pkg::REM_W-9:0], rx_byte};
		rem_dec      = (rem_q != '0) ? rem_q - {{(wfd_pkg::REM_W-1){1'b0}}, 1'b1} : '0;
		rem_dec_zero = (rem_dec == '0);
		seen_inc     = seen_q + 2'd1;
		shift_new    = {shift_q[7:0], rx_byte};
		msg_text     = (mtype_q == wfd_pkg::OP_TEXT);

		// frame length becomes known on this byte
		start_go  = 1'b0;
		start_rem = '0;
		if (phase_q == wfd_pkg::PH_HDR1) begin
			start_go  = !mask_err && !len_ext;
			start_rem = {{(wfd_pkg::REM_W-7){1'b0}}, len7};
		end else if (phase_q == wfd_pkg::PH_EXTLEN) begin
			start_go  = !msb_err && (len_left_dec == 4'd0);
			start_rem = ext_rem;
		end
		start_zero  = (start_rem == '0);
		start_close = (ftype_q == wfd_pkg::OP_CLOSE);

		// phase that follows a frame start
		if (start_close) begin
			start_phase = start_zero ? wfd_pkg::PH_STOP : wfd_pkg::PH_CLOSE;
		end else if (!start_zero) begin
			start_phase = wfd_pkg::PH_DATA;
		end else if (final_q && !msg_text) begin
			start_phase = wfd_pkg::PH_STOP;
		end else begin
			start_phase = wfd_pkg::PH_HDR0;
		end
	end

	// next state
	always_comb begin
		phase_d    = phase_q;
		len_left_d = len_left_q;
		rem_d      = rem_q;
		final_d    = final_q;
		ftype_d    = ftype_q;
		mtype_d    = mtype_q;
		shift_d    = shift_q;
		seen_d     = seen_q;
		case (phase_q)
			wfd_pkg::PH_HDR0: begin
				final_d = rx_byte[7];
				ftype_d = rx_byte[3:0];
				if (rx_byte[3:0] != wfd_pkg::OP_CONT) begin
					mtype_d = rx_byte[3:0];
				end
				phase_d = wfd_pkg::PH_HDR1;
			end
			wfd_pkg::PH_HDR1: begin
				if (mask_err) begin
					phase_d = wfd_pkg::PH_STOP;
				end else if (len_ext) begin
					rem_d      = '0;
					len_left_d = (len7 == wfd_pkg::LEN16_MARK) ? wfd_pkg::LEN16_BYTES
						: wfd_pkg::LEN64_BYTES;
					phase_d    = wfd_pkg::PH_EXTLEN;
				end else begin
					rem_d   = start_rem;
					phase_d = start_phase;
				end
			end
			wfd_pkg::PH_EXTLEN: begin
				if (msb_err) begin
					phase_d = wfd_pkg::PH_STOP;
				end else begin
					rem_d      = ext_rem;
					len_left_d = len_left_dec;
					if (start_go) begin
						phase_d = start_phase;
					end
				end
			end
			wfd_pkg::PH_DATA: begin
				rem_d = rem_dec;
				if (rem_dec_zero) begin
					phase_d = (final_q && !msg_text) ? wfd_pkg::PH_STOP : wfd_pkg::PH_HDR0;
				end
			end
			wfd_pkg::PH_CLOSE: begin
				shift_d = shift_new;
				seen_d  = seen_inc;
				rem_d   = rem_dec;
				if ((seen_inc >= 2'd2) || rem_dec_zero) begin
					phase_d = wfd_pkg::PH_STOP;
				end
			end
			default: begin
				phase_d = wfd_pkg::PH_STOP;
			end
		endcase
		// a close frame with payload starts collecting its status
		if (start_go && start_close && !start_zero) begin
			shift_d = '0;
			seen_d  = '0;
		end
	end

	// result of the current byte
	always_comb begin
		res = '0;
		case (phase_q)
			wfd_pkg::PH_HDR1, wfd_pkg::PH_EXTLEN: begin
				if ((phase_q == wfd_pkg::PH_HDR1) && mask_err) begin
					res.valid = 1'b1;
					res.kind  = wfd_pkg::KIND_ERROR;
					res.err   = wfd_pkg::ERR_MASKED;
				end else if ((phase_q == wfd_pkg::PH_EXTLEN) && msb_err) begin
					res.valid = 1'b1;
					res.kind  = wfd_pkg::KIND_ERROR;
					res.err   = wfd_pkg::ERR_LEN_MSB;
				end else if (start_go && start_zero) begin
					if (start_close) begin
						res.valid  = 1'b1;
						res.kind   = wfd_pkg::KIND_CLOSE;
						res.status = absent_close_status;
					end else if (final_q) begin
						res.valid = 1'b1;
						if (msg_text) begin
							res.kind = wfd_pkg::KIND_EMPTY;
						end else begin
							res.kind = wfd_pkg::KIND_ERROR;
							res.err  = wfd_pkg::ERR_TYPE;
						end
					end
				end
			end
			wfd_pkg::PH_DATA: begin
				res.valid = 1'b1;
				if (rem_dec_zero && final_q && !msg_text) begin
					res.kind = wfd_pkg::KIND_ERROR;
					res.err  = wfd_pkg::ERR_TYPE;
				end else begin
					res.kind = wfd_pkg::KIND_DATA;
					res.data = rx_byte;
					res.last = rem_dec_zero && final_q;
				end
			end
			wfd_pkg::PH_CLOSE: begin
				if (seen_inc >= 2'd2) begin
					res.valid  = 1'b1;
					res.kind   = wfd_pkg::KIND_CLOSE;
					res.status = shift_new;
				end else if (rem_dec_zero) begin
					res.valid  = 1'b1;
					res.kind   = wfd_pkg::KIND_CLOSE;
					res.status = absent_close_status;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wfd_pkg::PH_HDR0;
			len_left_q <= '0;
			rem_q      <= '0;
			final_q    <= 1'b0;
			ftype_q    <= '0;
			mtype_q    <= '0;
			shift_q    <= '0;
			seen_q     <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			len_left_q <= len_left_d;
			rem_q      <= rem_d;
			final_q    <= final_d;
			ftype_q    <= ftype_d;
			mtype_q    <= mtype_d;
			shift_q    <= shift_d;
			seen_q     <= seen_d;
		end
	end

endmodule

`default_nettype wire

// ===== verif/frame_parse_checker.sv =====
module frame_parse_checker
	import wfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  data_byte,
	input  logic        message_last,
	input  logic [15:0] close_status,
	input  logic [1:0]  error_code,
	output int          mismatch_count,
	output int          results_due
);

	localparam logic [1:0] NO_ERROR = 2'd0;

	// parser state of the prediction
	phase_t      parse_phase;
	logic [3:0]  ext_len_left;
	logic [62:0] payload_left;
	logic        frame_fin;
	logic [3:0]  frame_op;
	logic [3:0]  message_op;
	logic [15:0] status_acc;
	logic [1:0]  status_count;
	logic [15:0] close_default;

	result_t frame_results[$];
	int      result_index;

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("checker: result %0d at %0t: %s", result_index, $time, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	function automatic result_t make_result(input logic [1:0] k, input logic [7:0] d,
		input logic l, input logic [15:0] s, input logic [1:0] e);
		result_t r;
		r.valid  = 1'b1;
		r.kind   = k;
		r.data   = d;
		r.last   = l;
		r.status = s;
		r.err    = e;
		return r;
	endfunction

	// protocol error: the parser stops for good
	function automatic bit stop_on_error(input logic [1:0] e, output result_t r);
		parse_phase = PH_STOP;
		r = make_result(KIND_ERROR, 8'h00, 1'b0, 16'h0000, e);
		return 1'b1;
	endfunction

	// payload length of the frame is now known
	function automatic bit start_payload(output result_t r);
		r = '0;
		if (frame_op == OP_CLOSE) begin
			if (payload_left == '0) begin
				parse_phase = PH_STOP;
				r = make_result(KIND_CLOSE, 8'h00, 1'b0, close_default, NO_ERROR);
				return 1'b1;
			end
			status_acc   = '0;
			status_count = '0;
			parse_phase  = PH_CLOSE;
			return 1'b0;
		end
		if (payload_left != '0) begin
			parse_phase = PH_DATA;
			return 1'b0;
		end
		parse_phase = PH_HDR0;
		if (!frame_fin)
			return 1'b0;
		if (message_op == OP_TEXT) begin
			r = make_result(KIND_EMPTY, 8'h00, 1'b0, 16'h0000, NO_ERROR);
			return 1'b1;
		end
		return stop_on_error(ERR_TYPE, r);
	endfunction

	// advance the parser by one received byte, return 1 when it gives a result
	function automatic bit parse_rx_byte(input logic [7:0] b, output result_t r);
		r = '0;
		case (parse_phase)
			PH_HDR0: begin
				frame_fin = b[7];
				frame_op  = b[3:0];
				if (frame_op != OP_CONT)
					message_op = frame_op;
				parse_phase = PH_HDR1;
				return 1'b0;
			end
			PH_HDR1: begin
				if (b[7])
					return stop_on_error(ERR_MASKED, r);
				payload_left = '0;
				if (b[6:0] == LEN16_MARK || b[6:0] == LEN64_MARK) begin
					ext_len_left = (b[6:0] == LEN16_MARK) ? LEN16_BYTES : LEN64_BYTES;
					parse_phase  = PH_EXTLEN;
					return 1'b0;
				end
				payload_left = 63'(b[6:0]);
				return start_payload(r);
			end
			PH_EXTLEN: begin
				if (ext_len_left == LEN64_BYTES && b[7])
					return stop_on_error(ERR_LEN_MSB, r);
				payload_left = {payload_left[54:0], b};
				if (ext_len_left != '0)
					ext_len_left = ext_len_left - 4'd1;
				if (ext_len_left != '0)
					return 1'b0;
				return start_payload(r);
			end
			PH_DATA: begin
				if (payload_left != '0)
					payload_left = payload_left - 63'd1;
				if (payload_left == '0)
					parse_phase = PH_HDR0;
				if (payload_left == '0 && frame_fin && message_op != OP_TEXT)
					return stop_on_error(ERR_TYPE, r);
				r = make_result(KIND_DATA, b, payload_left == '0 && frame_fin, 16'h0000,
					NO_ERROR);
				return 1'b1;
			end
			PH_CLOSE: begin
				status_acc   = {status_acc[7:0], b};
				status_count = status_count + 2'd1;
				if (payload_left != '0)
					payload_left = payload_left - 63'd1;
				if (status_count >= 2'd2 || payload_left == '0) begin
					parse_phase = PH_STOP;
					r = make_result(KIND_CLOSE, 8'h00, 1'b0,
						(status_count >= 2'd2) ? status_acc : close_default, NO_ERROR);
					return 1'b1;
				end
				return 1'b0;
			end
			default: begin
				parse_phase = PH_STOP;
				return 1'b0;
			end
		endcase
	endfunction

	// watch the register port and both channels at each edge
	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t pred;
		if (!arst_n) begin
			parse_phase   = PH_HDR0;
			ext_len_left  = '0;
			payload_left  = '0;
			frame_fin     = 1'b0;
			frame_op      = OP_CONT;
			message_op    = OP_CONT;
			status_acc    = '0;
			status_count  = '0;
			close_default = ABSENT_CLOSE_RESET;
			frame_results.delete();
			results_due   = 0;
		end else begin
			// compare an accepted result with the oldest prediction
			if (out_valid && out_ready) begin
				result_index++;
				if (frame_results.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					want = frame_results.pop_front();
					check_field("kind", 16'(kind), 16'(want.kind));
					check_field("data_byte", 16'(data_byte), 16'(want.data));
					check_field("message_last", 16'(message_last), 16'(want.last));
					check_field("close_status", close_status, want.status);
					check_field("error_code", 16'(error_code), 16'(want.err));
				end
			end
			if (cfg_wr_en)
				close_default = cfg_wr_data;
			// predict from an accepted byte
			if (in_valid && in_ready) begin
				if (parse_rx_byte(rx_byte, pred))
					frame_results.push_back(pred);
			end
			results_due = frame_results.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
module tb;
	import wfd_pkg::*;

	localparam int LEN_FORM7       = 0;
	localparam int LEN_FORM16      = 1;
	localparam int LEN_FORM64      = 2;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int QUIET_CYCLES    = 4;
	localparam logic [3:0] OP_BINARY = 4'd2;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        in_valid    = 1'b0;
	logic [7:0]  rx_byte     = '0;
	logic        out_ready   = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic        message_last;
	logic [15:0] close_status;
	logic [1:0]  error_code;

	int mismatch_count;
	int results_due;
	int bytes_accepted = 0;
	bit idle_on        = 1'b1;
	bit hold_off_req   = 1'b0;

	websocket_frame_deframer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.data_byte    (data_byte),
		.message_last (message_last),
		.close_status (close_status),
		.error_code   (error_code)
	);

	frame_parse_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.data_byte      (data_byte),
		.message_last   (message_last),
		.close_status   (close_status),
		.error_code     (error_code),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	initial begin
		#2000000;
		$display("tb: done, errors");
		$finish;
	end

	// result side: random stall bursts, one long hold-off on request
	initial begin
		forever begin
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// offer one byte, with an occasional gap first, and wait until taken
	task automatic send_byte(input logic [7:0] b);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		bytes_accepted++;
	endtask

	task automatic send_header(input logic fin, input logic [3:0] op, input logic mask,
		input int len, input int form);
		logic [2:0]  rsv;
		logic [15:0] len16;
		rsv   = 3'($urandom);
		len16 = 16'(len);
		send_byte({fin, rsv, op});
		case (form)
			LEN_FORM16: begin
				send_byte({mask, LEN16_MARK});
				send_byte(len16[15:8]);
				send_byte(len16[7:0]);
			end
			LEN_FORM64: begin
				send_byte({mask, LEN64_MARK});
				repeat (6) send_byte(8'h00);
				send_byte(len16[15:8]);
				send_byte(len16[7:0]);
			end
			default: send_byte({mask, len16[6:0]});
		endcase
	endtask

	// extended forms also carry short lengths
	function automatic int pick_form(input int len);
		int form;
		case ($urandom_range(0, 3))
			0: form = LEN_FORM16;
			1: form = LEN_FORM64;
			default: form = (len >= LEN16_MARK) ? LEN_FORM16 : LEN_FORM7;
		endcase
		return form;
	endfunction

	// mostly short payloads, some empty, a few longer
	function automatic int pick_len();
		int len;
		case ($urandom_range(0, 9))
			0: len = 0;
			9: len = $urandom_range(13, 60);
			default: len = $urandom_range(1, 12);
		endcase
		return len;
	endfunction

	task automatic send_frame(input logic fin, input logic [3:0] op, input int len);
		send_header(fin, op, 1'b0, len, pick_form(len));
		repeat (len) send_byte(8'($urandom));
	endtask

	// text message in fragments, sometimes after a stray non-final frame
	task automatic send_message();
		int frags;
		logic [3:0] stray_op;
		if ($urandom_range(0, 4) == 0) begin
			stray_op = 4'($urandom_range(0, 14));
			if (stray_op >= OP_CLOSE)
				stray_op = stray_op + 4'd1;
			send_frame(1'b0, stray_op, pick_len());
		end
		frags = $urandom_range(1, 3);
		for (int i = 0; i < frags; i++)
			send_frame(i == frags - 1, (i == 0) ? OP_TEXT : OP_CONT, pick_len());
	endtask

	// stop offering and let every predicted result drain
	task automatic wait_quiet();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_close_default(input logic [15:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin
		logic [15:0] next_default;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_close_default(16'h0000);

		// empty final text frame
		send_header(1'b1, OP_TEXT, 1'b0, 0, LEN_FORM7);
		// fragment, then continuation with a short 16-bit length
		send_header(1'b0, OP_TEXT, 1'b0, 1, LEN_FORM7);
		send_byte(8'hFF);
		send_header(1'b1, OP_CONT, 1'b0, 2, LEN_FORM16);
		send_byte(8'h00);
		send_byte(8'h5A);
		// empty non-final binary frame, continuation with a short 64-bit length
		send_header(1'b0, OP_BINARY, 1'b0, 0, LEN_FORM7);
		send_header(1'b0, OP_CONT, 1'b0, 1, LEN_FORM64);
		send_byte(8'hA5);
		// all reserved bits set on a one-byte text message
		send_byte({1'b1, 3'b111, OP_TEXT});
		send_byte(8'h01);
		send_byte(8'h80);

		// random messages in phases, register rewritten between them
		for (int ph = 0; ph < 4; ph++) begin
			idle_on = (ph != 3);
			if (ph == 1) begin
				hold_off_req = 1'b1;
				send_frame(1'b1, OP_TEXT, 48);
			end
			while (bytes_accepted < 130 + 100 * ph)
				send_message();
			wait_quiet();
			case (ph)
				0: next_default = 16'hFFFF;
				1, 2: next_default = 16'($urandom);
				default: begin
					case ($urandom_range(0, 2))
						0: next_default = 16'h0000;
						1: next_default = 16'hFFFF;
						default: next_default = 16'($urandom);
					endcase
				end
			endcase
			write_close_default(next_default);
		end

		// frames that end the stream, then bytes that must be dropped
		case ($urandom_range(0, 6))
			0: send_header(1'b1, OP_TEXT, 1'b1, pick_len(), pick_form(20));
			1: begin
				send_byte({1'b1, 3'b000, OP_TEXT});
				send_byte({1'b0, LEN64_MARK});
				send_byte(8'h80 | 8'($urandom));
			end
			2: begin
				send_frame(1'b0, OP_BINARY, $urandom_range(1, 4));
				send_frame(1'b1, OP_CONT, $urandom_range(1, 4));
			end
			3: send_frame(1'b1, 4'($urandom_range(2, 7)), 0);
			4: send_frame(1'b1, OP_CLOSE, 0);
			5: send_frame(1'b1, OP_CLOSE, 1);
			default: send_frame(1'b1, OP_CLOSE, $urandom_range(2, 6));
		endcase
		repeat (10) send_byte(8'($urandom));

		wait_quiet();
		repeat (QUIET_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_due == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
